[hw/rtl/nnue_pkg.sv]
// nnue_pkg: shared types and constants of the nnue accumulator / screlu evaluation core
// used by all modules of the core; the channel interfaces do not depend on it
package nnue_pkg;

   localparam int FEATURE_COUNT = 768;
   localparam int COLOUR_STRIDE = 64 * 6;
   localparam logic [9:0] SQUARE_FLIP = 10'b00_0011_1000;
   localparam int SLOT_COUNT = 3;
   localparam int DIV_W = 25;

   localparam logic [14:0] CLIP_RESET  = 15'd255;
   localparam logic [9:0]  QUANT_RESET = 10'd64;
   localparam logic [11:0] SCALE_RESET = 12'd400;

   localparam logic [1:0] CSR_CLIP  = 2'd0;
   localparam logic [1:0] CSR_QUANT = 2'd1;
   localparam logic [1:0] CSR_SCALE = 2'd2;

   typedef enum logic [1:0] {ACT_LOAD, ACT_RESET, ACT_UPDATE, ACT_EVAL} action_type;
   typedef enum logic [1:0] {SEL_FW, SEL_FB, SEL_OW, SEL_OB} param_sel_type;
   typedef enum logic [1:0] {OP_NONE, OP_BIAS, OP_UPD, OP_EVAL} dp_op_type;
   typedef enum logic {DIV_SUM, DIV_SCALED} div_sel_type;

   typedef struct packed {
      logic        accept_en;
      dp_op_type   op;
      logic        row_setup;
      logic [1:0]  slot;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_t;
      logic        take_m;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic       accept;
      action_type action;
      logic [SLOT_COUNT-1:0] slot_en;
      logic       busy;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

endpackage

[hw/rtl/nnue_req_if.sv]
// nnue_req_if: request channel of the nnue core, valid/ready with item payload
// standalone, no dependencies
interface nnue_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [1:0]         param_select;
   logic [17:0]        param_address;
   logic signed [15:0] param_value;
   logic [9:0]         add_feature;
   logic               add_valid;
   logic [9:0]         sub_feature;
   logic               sub_valid;
   logic [9:0]         second_sub_feature;
   logic               second_sub_valid;
   logic               white_to_move;
   logic [2:0]         output_bucket;

   modport source (output valid, action, param_select, param_address, param_value,
      add_feature, add_valid, sub_feature, sub_valid, second_sub_feature,
      second_sub_valid, white_to_move, output_bucket, input ready);
   modport sink (input valid, action, param_select, param_address, param_value,
      add_feature, add_valid, sub_feature, sub_valid, second_sub_feature,
      second_sub_valid, white_to_move, output_bucket, output ready);
endinterface

[hw/rtl/nnue_rsp_if.sv]
// nnue_rsp_if: result channel of the nnue core, valid/ready with evaluation payload
// standalone, no dependencies
interface nnue_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] evaluation;

   modport source (output valid, evaluation, input ready);
   modport sink (input valid, evaluation, output ready);
endinterface

[hw/rtl/nnue_accumulator_screlu_eval_core.sv]
// nnue_accumulator_screlu_eval_core: top level, joins the sequencer and the datapath
// load completes on accept; reset walks the hidden index once; update walks it once for
// each valid in-range feature; evaluate takes one hidden word per cycle over both views,
// a pipeline drain, then two divider passes; one transaction at a time
// reset clears control and restores clip 255, quant 64, scale 400; stores and
// accumulators hold nothing defined until loaded or reset by a transaction
module nnue_accumulator_screlu_eval_core #(
   parameter int HIDDEN_SIZE = 256,
   parameter int BUCKET_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   nnue_req_if.sink    req_bus,
   nnue_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   localparam int IDX_W = $clog2(HIDDEN_SIZE);

   nnue_pkg::dp_cmd_type    cmd;
   nnue_pkg::dp_status_type status;
   logic [IDX_W-1:0]        cmd_index;

   nnue_ctrl #(
      .HIDDEN_SIZE (HIDDEN_SIZE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .cmd_index (cmd_index)
   );

   nnue_dp #(
      .HIDDEN_SIZE  (HIDDEN_SIZE),
      .BUCKET_COUNT (BUCKET_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .cmd_index (cmd_index),
      .status    (status)
   );
endmodule

[hw/rtl/nnue_div.sv]
// nnue_div: iterative divider, one quotient bit per cycle, truncates toward zero
// signed dividend, unsigned divisor; depends on nnue_pkg for the divisor width
module nnue_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [nnue_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [31:0]                quotient
);
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [31:0]                num_ff, num_in;
   logic [nnue_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [nnue_pkg::DIV_W-1:0] den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [nnue_pkg::DIV_W:0]   sh;
   logic [nnue_pkg::DIV_W:0]   diff;
   logic                       ge;

   assign sh   = {rem_ff, num_ff[31]};
   assign diff = sh - {1'b0, den_ff};
   assign ge   = sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[31];
      end else if (busy_ff) begin
         rem_in = ge ? diff[nnue_pkg::DIV_W-1:0] : sh[nnue_pkg::DIV_W-1:0];
         num_in = {num_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - num_ff) : num_ff;
endmodule

[hw/rtl/nnue_ctrl.sv]
// nnue_ctrl: sequencer of the nnue core, walks the hidden index and orders the eval steps
// depends on nnue_pkg for command and status types
module nnue_ctrl #(
   parameter int HIDDEN_SIZE = 256,
   localparam int IDX_W = $clog2(HIDDEN_SIZE)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nnue_pkg::dp_status_type status,
   output nnue_pkg::dp_cmd_type    cmd,
   output logic [IDX_W-1:0]        cmd_index
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_BIAS, ST_PICK, ST_UPD, ST_EVAL, ST_DRAIN,
      ST_DIV1, ST_MUL, ST_DIV2S, ST_DIV2, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [1:0]       slot_ff;
   logic             last;
   logic             slot_hit;
   logic             slot_end;

   assign last      = idx_ff == IDX_W'(HIDDEN_SIZE - 1);
   assign slot_end  = slot_ff == 2'(nnue_pkg::SLOT_COUNT);
   assign slot_hit  = !slot_end && status.slot_en[slot_ff];
   assign cmd_index = idx_ff;

   always_comb begin
      cmd           = '0;
      cmd.op        = nnue_pkg::OP_NONE;
      cmd.div_sel   = nnue_pkg::DIV_SUM;
      cmd.accept_en = state_ff == ST_IDLE;
      case (state_ff)
         ST_BIAS: cmd.op = nnue_pkg::OP_BIAS;
         ST_PICK: begin
            cmd.row_setup = slot_hit;
            cmd.slot      = slot_ff;
         end
         ST_UPD:   cmd.op = nnue_pkg::OP_UPD;
         ST_EVAL:  cmd.op = nnue_pkg::OP_EVAL;
         ST_DRAIN: cmd.div_start = !status.busy;
         ST_DIV1:  cmd.take_t = status.div_done;
         ST_MUL:   cmd.take_m = 1'b1;
         ST_DIV2S: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = nnue_pkg::DIV_SCALED;
         end
         ST_OUT:   cmd.out_load = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               idx_ff  <= '0;
               slot_ff <= '0;
               if (status.accept) begin
                  case (status.action)
                     nnue_pkg::ACT_RESET:  state_ff <= ST_BIAS;
                     nnue_pkg::ACT_UPDATE: state_ff <= ST_PICK;
                     nnue_pkg::ACT_EVAL:   state_ff <= ST_EVAL;
                     default:              state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_BIAS: begin
               idx_ff <= last ? '0 : idx_ff + 1'b1;
               if (last) state_ff <= ST_IDLE;
            end
            ST_PICK: begin
               idx_ff <= '0;
               if (slot_end) begin
                  state_ff <= ST_IDLE;
               end else if (slot_hit) begin
                  state_ff <= ST_UPD;
               end else begin
                  slot_ff <= slot_ff + 2'd1;
               end
            end
            ST_UPD: begin
               idx_ff <= last ? '0 : idx_ff + 1'b1;
               if (last) begin
                  slot_ff  <= slot_ff + 2'd1;
                  state_ff <= ST_PICK;
               end
            end
            ST_EVAL: begin
               idx_ff <= last ? '0 : idx_ff + 1'b1;
               if (last) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: if (!status.busy) state_ff <= ST_DIV1;
            ST_DIV1:  if (status.div_done) state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_DIV2S;
            ST_DIV2S: state_ff <= ST_DIV2;
            ST_DIV2:  if (status.div_done) state_ff <= ST_OUT;
            ST_OUT:   if (status.out_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   a_div_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.busy)
      else $error("divider started with accumulation pipeline busy");
   a_no_accept_in_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != nnue_pkg::OP_NONE) |-> !status.accept)
      else $error("transaction accepted during accumulator walk");
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output register full");
endmodule

[hw/rtl/nnue_dp.sv]
// nnue_dp: datapath of the nnue core with parameter stores, accumulators and eval pipeline
// depends on nnue_pkg, nnue_req_if, nnue_rsp_if and nnue_div
module nnue_dp #(
   parameter int HIDDEN_SIZE = 256,
   parameter int BUCKET_COUNT = 8,
   localparam int IDX_W = $clog2(HIDDEN_SIZE)
) (
   input  logic                    clock,
   input  logic                    reset,
   nnue_req_if.sink                req,
   nnue_rsp_if.source              rsp,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [14:0]             csr_wdata,
   input  nnue_pkg::dp_cmd_type    cmd,
   input  logic [IDX_W-1:0]        cmd_index,
   output nnue_pkg::dp_status_type status
);
   localparam int FW_DEPTH = nnue_pkg::FEATURE_COUNT * HIDDEN_SIZE;
   localparam int FW_AW    = $clog2(FW_DEPTH);
   localparam int OW_DEPTH = 2 * HIDDEN_SIZE * BUCKET_COUNT;
   localparam int OW_AW    = $clog2(OW_DEPTH);
   localparam int OB_AW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

   logic [15:0] fw_mem [FW_DEPTH];
   logic [15:0] fb_mem [HIDDEN_SIZE];
   logic [15:0] ow_mem [OW_DEPTH];
   logic [15:0] ob_ff  [BUCKET_COUNT];
   logic [15:0] accw_mem [HIDDEN_SIZE];
   logic [15:0] accb_mem [HIDDEN_SIZE];

   logic [14:0] clip_ff;
   logic [9:0]  quant_ff;
   logic [11:0] scale_ff;
   logic [nnue_pkg::DIV_W-1:0] cq_ff;

   logic accept, is_load;
   logic fw_we, fb_we, ow_we, ob_we;
   logic [31:0] addr32;

   logic [9:0] fadd_ff, fsub_ff, fsub2_ff;
   logic [nnue_pkg::SLOT_COUNT-1:0] slot_en_ff;
   logic wtm_ff;
   logic [OB_AW-1:0] bucket_ff;
   logic [OW_AW-1:0] obase_ff;
   logic [4:0] bmod;
   logic [OW_AW-1:0] obase_in;

   logic [9:0] sel_feat, rest, wrow, brow;
   logic colour;
   logic [FW_AW-1:0] wbase_ff, bbase_ff;
   logic sub_ff;

   logic [FW_AW-1:0] fw_ra0, fw_ra1;
   logic [OW_AW-1:0] ow_ra0, ow_ra1;
   logic [15:0] fw_q0_ff, fw_q1_ff, fb_q_ff, ow_q0_ff, ow_q1_ff, aw_q_ff, ab_q_ff;

   nnue_pkg::dp_op_type s1_op_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic acc_we;
   logic [15:0] accw_wd, accb_wd;

   logic signed [15:0] au, at, wu, wt;
   logic [14:0] cu, ct;
   logic signed [31:0] mul_u, mul_t;
   logic s2_v_ff, s3_v_ff;
   logic [14:0] cu_ff, ct_ff;
   logic signed [15:0] pu_ff, pt_ff;
   logic signed [31:0] ru, rt, ru_ff, rt_ff;
   logic [31:0] sum_ff;

   logic [31:0] div_dividend, div_q;
   logic [nnue_pkg::DIV_W-1:0] div_divisor;
   logic div_done;
   logic [31:0] t_ff, m_ff;
   logic [43:0] mprod;
   logic [15:0] ob_sel;

   logic rsp_valid_ff;
   logic [31:0] eval_ff;

   function automatic logic [14:0] clamp_act(logic signed [15:0] a, logic [14:0] lim);
      if (a[15]) return 15'd0;
      else if (a[14:0] > lim) return lim;
      else return a[14:0];
   endfunction

   // configuration, a zero write acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff  <= nnue_pkg::CLIP_RESET;
         quant_ff <= nnue_pkg::QUANT_RESET;
         scale_ff <= nnue_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nnue_pkg::CSR_CLIP:  clip_ff  <= (csr_wdata == '0) ? 15'd1 : csr_wdata;
            nnue_pkg::CSR_QUANT: quant_ff <= (csr_wdata[9:0] == '0) ? 10'd1 : csr_wdata[9:0];
            nnue_pkg::CSR_SCALE: scale_ff <= (csr_wdata[11:0] == '0) ? 12'd1 : csr_wdata[11:0];
            default: ;
         endcase
      end
      cq_ff <= nnue_pkg::DIV_W'(clip_ff) * nnue_pkg::DIV_W'(quant_ff);
   end

   assign req.ready = cmd.accept_en;
   assign accept    = req.valid && req.ready;
   assign is_load   = accept && (req.action == nnue_pkg::ACT_LOAD);
   assign addr32    = 32'(req.param_address);
   assign fw_we = is_load && (req.param_select == nnue_pkg::SEL_FW) && (addr32 < 32'(FW_DEPTH));
   assign fb_we = is_load && (req.param_select == nnue_pkg::SEL_FB)
                  && (addr32 < 32'(HIDDEN_SIZE));
   assign ow_we = is_load && (req.param_select == nnue_pkg::SEL_OW) && (addr32 < 32'(OW_DEPTH));
   assign ob_we = is_load && (req.param_select == nnue_pkg::SEL_OB)
                  && (addr32 < 32'(BUCKET_COUNT));

   // bucket modulo the bucket count
   always_comb begin
      bmod = {2'b00, req.output_bucket};
      for (int k = 0; k < 8; k++) begin
         if (bmod >= 5'(BUCKET_COUNT)) bmod = bmod - 5'(BUCKET_COUNT);
      end
      obase_in = OW_AW'(32'(bmod) * (2 * HIDDEN_SIZE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_en_ff <= '0;
      end else if (accept) begin
         slot_en_ff <= {
            req.second_sub_valid && (req.second_sub_feature < 10'(nnue_pkg::FEATURE_COUNT)),
            req.sub_valid && (req.sub_feature < 10'(nnue_pkg::FEATURE_COUNT)),
            req.add_valid && (req.add_feature < 10'(nnue_pkg::FEATURE_COUNT))};
      end
      if (accept) begin
         fadd_ff   <= req.add_feature;
         fsub_ff   <= req.sub_feature;
         fsub2_ff  <= req.second_sub_feature;
         wtm_ff    <= req.white_to_move;
         bucket_ff <= OB_AW'(bmod);
         obase_ff  <= obase_in;
      end
   end

   // per view row of the selected feature
   always_comb begin
      sel_feat = (cmd.slot == 2'd0) ? fadd_ff : ((cmd.slot == 2'd1) ? fsub_ff : fsub2_ff);
      colour   = sel_feat >= 10'(nnue_pkg::COLOUR_STRIDE);
      rest     = colour ? (sel_feat - 10'(nnue_pkg::COLOUR_STRIDE)) : sel_feat;
      wrow     = colour ? (10'(nnue_pkg::COLOUR_STRIDE) + (rest ^ nnue_pkg::SQUARE_FLIP))
                        : (rest ^ nnue_pkg::SQUARE_FLIP);
      brow     = colour ? rest : (rest + 10'(nnue_pkg::COLOUR_STRIDE));
   end

   always_ff @(posedge clock) begin
      if (cmd.row_setup) begin
         wbase_ff <= FW_AW'(32'(wrow) * HIDDEN_SIZE);
         bbase_ff <= FW_AW'(32'(brow) * HIDDEN_SIZE);
         sub_ff   <= cmd.slot != 2'd0;
      end
   end

   assign fw_ra0 = wbase_ff + FW_AW'(cmd_index);
   assign fw_ra1 = bbase_ff + FW_AW'(cmd_index);
   assign ow_ra0 = obase_ff + OW_AW'(cmd_index);
   assign ow_ra1 = obase_ff + OW_AW'(HIDDEN_SIZE) + OW_AW'(cmd_index);

   always_ff @(posedge clock) begin
      if (fw_we) fw_mem[FW_AW'(req.param_address)] <= req.param_value;
      fw_q0_ff <= fw_mem[fw_ra0];
      fw_q1_ff <= fw_mem[fw_ra1];
   end

   always_ff @(posedge clock) begin
      if (fb_we) fb_mem[IDX_W'(req.param_address)] <= req.param_value;
      fb_q_ff <= fb_mem[cmd_index];
   end

   always_ff @(posedge clock) begin
      if (ow_we) ow_mem[OW_AW'(req.param_address)] <= req.param_value;
      ow_q0_ff <= ow_mem[ow_ra0];
      ow_q1_ff <= ow_mem[ow_ra1];
   end

   always_ff @(posedge clock) begin
      if (ob_we) ob_ff[OB_AW'(req.param_address)] <= req.param_value;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_op_ff <= nnue_pkg::OP_NONE;
      else       s1_op_ff <= cmd.op;
      s1_idx_ff <= cmd_index;
   end

   assign acc_we  = (s1_op_ff == nnue_pkg::OP_BIAS) || (s1_op_ff == nnue_pkg::OP_UPD);
   assign accw_wd = (s1_op_ff == nnue_pkg::OP_BIAS) ? fb_q_ff
                  : (sub_ff ? (aw_q_ff - fw_q0_ff) : (aw_q_ff + fw_q0_ff));
   assign accb_wd = (s1_op_ff == nnue_pkg::OP_BIAS) ? fb_q_ff
                  : (sub_ff ? (ab_q_ff - fw_q1_ff) : (ab_q_ff + fw_q1_ff));

   always_ff @(posedge clock) begin
      if (acc_we) accw_mem[s1_idx_ff] <= accw_wd;
      aw_q_ff <= accw_mem[cmd_index];
   end

   always_ff @(posedge clock) begin
      if (acc_we) accb_mem[s1_idx_ff] <= accb_wd;
      ab_q_ff <= accb_mem[cmd_index];
   end

   // screlu pipeline: clamp and first product, second product, sum
   assign au    = wtm_ff ? aw_q_ff : ab_q_ff;
   assign at    = wtm_ff ? ab_q_ff : aw_q_ff;
   assign wu    = ow_q0_ff;
   assign wt    = ow_q1_ff;
   assign cu    = clamp_act(au, clip_ff);
   assign ct    = clamp_act(at, clip_ff);
   assign mul_u = $signed({1'b0, cu}) * wu;
   assign mul_t = $signed({1'b0, ct}) * wt;
   assign ru    = pu_ff * $signed({1'b0, cu_ff});
   assign rt    = pt_ff * $signed({1'b0, ct_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_op_ff == nnue_pkg::OP_EVAL;
         s3_v_ff <= s2_v_ff;
      end
      cu_ff <= cu;
      ct_ff <= ct;
      pu_ff <= mul_u[15:0];
      pt_ff <= mul_t[15:0];
      ru_ff <= ru;
      rt_ff <= rt;
      if (accept)       sum_ff <= '0;
      else if (s3_v_ff) sum_ff <= sum_ff + ru_ff + rt_ff;
   end

   assign div_dividend = (cmd.div_sel == nnue_pkg::DIV_SUM) ? sum_ff : m_ff;
   assign div_divisor  = (cmd.div_sel == nnue_pkg::DIV_SUM) ? nnue_pkg::DIV_W'(clip_ff) : cq_ff;

   nnue_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign ob_sel = ob_ff[bucket_ff];
   assign mprod  = 44'(t_ff) * 44'(scale_ff);

   always_ff @(posedge clock) begin
      if (cmd.take_t) t_ff <= div_q + {{16{ob_sel[15]}}, ob_sel};
      if (cmd.take_m) m_ff <= mprod[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) eval_ff <= div_q;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.evaluation = eval_ff;

   assign status.accept   = accept;
   assign status.action   = nnue_pkg::action_type'(req.action);
   assign status.slot_en  = slot_en_ff;
   assign status.busy     = (s1_op_ff != nnue_pkg::OP_NONE) || s2_v_ff || s3_v_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp.ready;
endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for nnue_accumulator_screlu_eval_core
// holds its own model of the stores, the two view accumulators and the evaluation
// depends on nnue_pkg, nnue_req_if, nnue_rsp_if and the core itself
`timescale 1ns / 1ps

module tb_top;

   localparam int HIDDEN = 256;
   localparam int BUCKETS = 8;
   localparam int FW_WORDS = nnue_pkg::FEATURE_COUNT * HIDDEN;
   localparam int OW_WORDS = 2 * HIDDEN * BUCKETS;
   localparam int PHASE_ITEMS = 146;
   localparam int SETTLE_CYCLES = 1000;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      nnue_pkg::action_type    act;
      nnue_pkg::param_sel_type sel;
      bit [17:0]     addr;
      bit [15:0]     val;
      bit [9:0]      add_f;
      bit            add_v;
      bit [9:0]      sub_f;
      bit            sub_v;
      bit [9:0]      sub2_f;
      bit            sub2_v;
      bit            wtm;
      bit [2:0]      bucket;
      bit            has_eval;
      int            eval_val;
   } board_op_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [14:0] csr_wdata;

   nnue_req_if req_if();
   nnue_rsp_if rsp_if();

   nnue_accumulator_screlu_eval_core dut (
      .clock(clock), .reset(reset), .req_bus(req_if), .rsp_bus(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bit [15:0] fw_mem [FW_WORDS];
   bit [15:0] fb_mem [HIDDEN];
   bit [15:0] ow_mem [OW_WORDS];
   bit [15:0] ob_mem [BUCKETS];
   bit [15:0] white_acc [HIDDEN];
   bit [15:0] black_acc [HIDDEN];
   bit [14:0] clip_reg = nnue_pkg::CLIP_RESET;
   bit [9:0]  quant_reg = nnue_pkg::QUANT_RESET;
   bit [11:0] scale_reg = nnue_pkg::SCALE_RESET;

   int eval_q[$];
   int errors, checked, n_load, n_reset, n_update, n_eval;
   int send_idle_pct, recv_stall_pct;
   int quiet_cycles;
   bit [9:0] pool[4] = '{10'd5, 10'd130, 10'd400, 10'd700};

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic void feature_rows(bit [9:0] f, output int wrow, output int brow);
      int colour, rest;
      colour = f / nnue_pkg::COLOUR_STRIDE;
      rest = f % nnue_pkg::COLOUR_STRIDE;
      wrow = colour * nnue_pkg::COLOUR_STRIDE + (rest ^ int'(nnue_pkg::SQUARE_FLIP));
      brow = (colour ^ 1) * nnue_pkg::COLOUR_STRIDE + rest;
   endfunction

   function automatic void apply_feature(bit [9:0] f, bit add);
      int wrow, brow;
      if (f >= nnue_pkg::FEATURE_COUNT) return;
      feature_rows(f, wrow, brow);
      for (int i = 0; i < HIDDEN; i++) begin
         if (add) begin
            white_acc[i] = white_acc[i] + fw_mem[wrow * HIDDEN + i];
            black_acc[i] = black_acc[i] + fw_mem[brow * HIDDEN + i];
         end else begin
            white_acc[i] = white_acc[i] - fw_mem[wrow * HIDDEN + i];
            black_acc[i] = black_acc[i] - fw_mem[brow * HIDDEN + i];
         end
      end
   endfunction

   function automatic int screlu_dot(bit white, int base, int clip);
      int sum, a, c, w;
      shortint p;
      sum = 0;
      for (int i = 0; i < HIDDEN; i++) begin
         a = shortint'(white ? white_acc[i] : black_acc[i]);
         c = a < 0 ? 0 : (a > clip ? clip : a);
         w = shortint'(ow_mem[base + i]);
         p = shortint'(c * w);
         sum += p * c;
      end
      return sum;
   endfunction

   function automatic int predict_eval(bit wtm, bit [2:0] bucket);
      int clip, quant, scale, base, sum, q, t, m;
      clip = clip_reg == 0 ? 1 : clip_reg;
      quant = quant_reg == 0 ? 1 : quant_reg;
      scale = scale_reg == 0 ? 1 : scale_reg;
      base = bucket * 2 * HIDDEN;
      sum = screlu_dot(wtm, base, clip) + screlu_dot(!wtm, base + HIDDEN, clip);
      q = sum / clip;
      t = q + shortint'(ob_mem[bucket]);
      m = int'(longint'(t) * scale);
      return int'(longint'(m) / (longint'(clip) * quant));
   endfunction

   function automatic void track_op(board_op_type op);
      case (op.act)
         nnue_pkg::ACT_LOAD: begin
            n_load++;
            case (op.sel)
               nnue_pkg::SEL_FW: if (op.addr < FW_WORDS) fw_mem[op.addr] = op.val;
               nnue_pkg::SEL_FB: if (op.addr < HIDDEN) fb_mem[op.addr] = op.val;
               nnue_pkg::SEL_OW: if (op.addr < OW_WORDS) ow_mem[op.addr] = op.val;
               nnue_pkg::SEL_OB: if (op.addr < BUCKETS) ob_mem[op.addr] = op.val;
               default: ;
            endcase
         end
         nnue_pkg::ACT_RESET: begin
            n_reset++;
            white_acc = fb_mem;
            black_acc = fb_mem;
         end
         nnue_pkg::ACT_UPDATE: begin
            n_update++;
            if (op.add_v) apply_feature(op.add_f, 1'b1);
            if (op.sub_v) apply_feature(op.sub_f, 1'b0);
            if (op.sub2_v) apply_feature(op.sub2_f, 1'b0);
         end
         nnue_pkg::ACT_EVAL: begin
            n_eval++;
            eval_q.push_back(op.has_eval ? op.eval_val : predict_eval(op.wtm, op.bucket));
         end
         default: ;
      endcase
   endfunction

   task automatic send(board_op_type op);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.action <= op.act;
      req_if.param_select <= op.sel;
      req_if.param_address <= op.addr;
      req_if.param_value <= op.val;
      req_if.add_feature <= op.add_f;
      req_if.add_valid <= op.add_v;
      req_if.sub_feature <= op.sub_f;
      req_if.sub_valid <= op.sub_v;
      req_if.second_sub_feature <= op.sub2_f;
      req_if.second_sub_valid <= op.sub2_v;
      req_if.white_to_move <= op.wtm;
      req_if.output_bucket <= op.bucket;
      do @(posedge clock); while (!req_if.ready);
      track_op(op);
   endtask

   function automatic board_op_type blank_op(nnue_pkg::action_type act);
      board_op_type op;
      op = '{act: act, sel: nnue_pkg::param_sel_type'($urandom_range(3)),
             addr: 18'($urandom), val: 16'($urandom), add_f: 10'($urandom), add_v: 0,
             sub_f: 10'($urandom), sub_v: 0, sub2_f: 10'($urandom), sub2_v: 0,
             wtm: 1'($urandom), bucket: 3'($urandom), has_eval: 0, eval_val: 0};
      return op;
   endfunction

   function automatic bit [15:0] rand_word();
      case ($urandom_range(7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return 16'($urandom);
         default: return 16'($signed($urandom_range(600)) - 300);
      endcase
   endfunction

   task automatic load_word(nnue_pkg::param_sel_type sel, int addr, bit [15:0] val);
      board_op_type op;
      op = blank_op(nnue_pkg::ACT_LOAD);
      op.sel = sel;
      op.addr = 18'(addr);
      op.val = val;
      send(op);
   endtask

   task automatic drain_and_settle();
      req_if.valid <= 1'b0;
      wait (eval_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(bit [1:0] idx, bit [14:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         nnue_pkg::CSR_CLIP: clip_reg = val;
         nnue_pkg::CSR_QUANT: quant_reg = val[9:0];
         nnue_pkg::CSR_SCALE: scale_reg = val[11:0];
         default: ;
      endcase
   endtask

   function automatic bit [9:0] pick_feature();
      if ($urandom_range(3) == 0) return 10'(nnue_pkg::FEATURE_COUNT + $urandom_range(255));
      return pool[2'($urandom_range(3))];
   endfunction

   function automatic board_op_type random_op();
      board_op_type op;
      int pick, wrow, brow;
      pick = $urandom_range(99);
      if (pick < 35) begin
         op = blank_op(nnue_pkg::ACT_LOAD);
         op.val = rand_word();
         if ($urandom_range(9) == 0) begin
            op.addr = 18'($urandom_range(18'h3ffff, FW_WORDS));
         end else case (op.sel)
            nnue_pkg::SEL_FW: begin
               feature_rows(pool[2'($urandom_range(3))], wrow, brow);
               op.addr = 18'(($urandom_range(1) ? wrow : brow) * HIDDEN
                             + $urandom_range(HIDDEN - 1));
            end
            nnue_pkg::SEL_FB: op.addr = 18'($urandom_range(HIDDEN - 1));
            nnue_pkg::SEL_OW: op.addr = 18'($urandom_range(OW_WORDS - 1));
            nnue_pkg::SEL_OB: op.addr = 18'($urandom_range(BUCKETS - 1));
            default: ;
         endcase
      end else if (pick < 43) begin
         op = blank_op(nnue_pkg::ACT_RESET);
      end else if (pick < 78) begin
         op = blank_op(nnue_pkg::ACT_UPDATE);
         op.add_v = 1'($urandom);
         op.sub_v = 1'($urandom);
         op.sub2_v = 1'($urandom);
         if (op.add_v) op.add_f = pick_feature();
         if (op.sub_v) op.sub_f = pick_feature();
         if (op.sub2_v) op.sub2_f = pick_feature();
      end else begin
         op = blank_op(nnue_pkg::ACT_EVAL);
      end
      return op;
   endfunction

   always @(posedge clock) begin
      rsp_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (eval_q.size() == 0) begin
            report("evaluation with none pending", rsp_if.evaluation, 0);
         end else begin
            checked++;
            if (rsp_if.evaluation !== eval_q[0])
               report("evaluation", rsp_if.evaluation, eval_q[0]);
            void'(eval_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      board_op_type table_ops[$];
      board_op_type op;
      int wrow, brow;
      bit [14:0] cfg_clip[8] = '{15'd255, 15'd1, 15'd32767, 15'd0, 15'd100, 15'd0,
                                 15'd32767, 15'd255};
      bit [14:0] cfg_quant[8] = '{15'd64, 15'd1, 15'd1023, 15'd0, 15'd32, 15'd0,
                                  15'd1, 15'd64};
      bit [14:0] cfg_scale[8] = '{15'd400, 15'd1, 15'd4095, 15'd0, 15'd256, 15'd0,
                                  15'd4095, 15'd400};

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= nnue_pkg::CSR_CLIP;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.action <= nnue_pkg::ACT_LOAD;
      req_if.param_select <= nnue_pkg::SEL_FW;
      req_if.param_address <= '0;
      req_if.param_value <= '0;
      req_if.add_feature <= '0;
      req_if.add_valid <= 1'b0;
      req_if.sub_feature <= '0;
      req_if.sub_valid <= 1'b0;
      req_if.second_sub_feature <= '0;
      req_if.second_sub_valid <= 1'b0;
      req_if.white_to_move <= 1'b0;
      req_if.output_bucket <= '0;
      cfg_clip[5] = 15'($urandom_range(32767, 1));
      cfg_quant[5] = 15'($urandom_range(1023, 1));
      cfg_scale[5] = 15'($urandom_range(4095, 1));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // parameters that any later read can reach
      for (int i = 0; i < HIDDEN; i++) load_word(nnue_pkg::SEL_FB, i, 16'h0000);
      for (int i = 0; i < OW_WORDS; i++) load_word(nnue_pkg::SEL_OW, i, rand_word());
      load_word(nnue_pkg::SEL_OB, 0, 16'h7fff);
      load_word(nnue_pkg::SEL_OB, 1, 16'h8000);
      for (int b = 2; b < BUCKETS; b++) load_word(nnue_pkg::SEL_OB, b, rand_word());
      foreach (pool[k]) begin
         feature_rows(pool[k], wrow, brow);
         for (int i = 0; i < HIDDEN; i++) begin
            load_word(nnue_pkg::SEL_FW, wrow * HIDDEN + i, rand_word());
            load_word(nnue_pkg::SEL_FW, brow * HIDDEN + i, rand_word());
         end
      end

      // directed: zero accumulators give bias * 400 / (255 * 64)
      op = blank_op(nnue_pkg::ACT_RESET); table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_EVAL); op.wtm = 1; op.bucket = 0;
      op.has_eval = 1; op.eval_val = 803; table_ops.push_back(op);
      op.wtm = 0; op.bucket = 1; op.eval_val = -803; table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_LOAD); op.sel = nnue_pkg::SEL_FB; op.addr = 0;
      op.val = 16'h7fff;
      table_ops.push_back(op);
      op.addr = 255; op.val = 16'h8000; table_ops.push_back(op);
      op.addr = 256; op.val = 16'h1234; table_ops.push_back(op);
      op.sel = nnue_pkg::SEL_OB; op.addr = 8; table_ops.push_back(op);
      op.sel = nnue_pkg::SEL_OW; op.addr = 18'(OW_WORDS); table_ops.push_back(op);
      op.sel = nnue_pkg::SEL_FW; op.addr = 18'h3ffff; table_ops.push_back(op);
      op.addr = 18'(FW_WORDS); table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_RESET); table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_EVAL); op.wtm = 1; op.bucket = 7; table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_UPDATE);
      op.add_v = 1; op.add_f = pool[0];
      op.sub_v = 1; op.sub_f = pool[1];
      op.sub2_v = 1; op.sub2_f = pool[2];
      table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_EVAL); op.wtm = 0; op.bucket = 3; table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_UPDATE);
      op.add_v = 1; op.add_f = 10'h3ff;
      op.sub_v = 1; op.sub_f = 10'd768;
      op.sub2_v = 1; op.sub2_f = pool[3];
      table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_UPDATE); table_ops.push_back(op);
      op.add_v = 1; op.add_f = pool[3]; table_ops.push_back(op);
      op = blank_op(nnue_pkg::ACT_EVAL); op.wtm = 1; op.bucket = 5; table_ops.push_back(op);
      op.wtm = 0; op.bucket = 2; table_ops.push_back(op);
      foreach (table_ops[k]) send(table_ops[k]);

      for (int phase = 0; phase < 8; phase++) begin
         drain_and_settle();
         if (phase != 0) begin
            write_csr(nnue_pkg::CSR_CLIP, cfg_clip[phase]);
            write_csr(nnue_pkg::CSR_QUANT, cfg_quant[phase]);
            write_csr(nnue_pkg::CSR_SCALE, cfg_scale[phase]);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send(random_op());
      end

      drain_and_settle();
      $display("run covered %0d loads, %0d accumulator resets, %0d updates, %0d evaluations",
               n_load, n_reset, n_update, n_eval);
      $display("%0d evaluations compared over 8 register settings, %0d mismatches",
               checked, errors);
      if (errors == 0 && eval_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
